/* rtl/core/pdwt_pkg.sv */
// pdwt_pkg: shared types and constants for the pulse-distance word transmitter.
// No dependencies; used by pdwt_regs, pdwt_seq and the top level.

package pdwt_pkg;

    // Configuration port geometry: six 32-bit registers at byte offsets 4*i
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int CFG_W  = 16;   // register field width as seen on the bus
    localparam int TICK_W = 17;   // holds gap + one_extra

    // Register indexes
    localparam logic [2:0] REG_SETUP     = 3'd0;
    localparam logic [2:0] REG_START     = 3'd1;
    localparam logic [2:0] REG_GAP       = 3'd2;
    localparam logic [2:0] REG_ONE_EXTRA = 3'd3;
    localparam logic [2:0] REG_TERM      = 3'd4;
    localparam logic [2:0] REG_END       = 3'd5;

    // Reset durations in ticks
    localparam logic [CFG_W-1:0] SETUP_RESET     = 16'd5000;
    localparam logic [CFG_W-1:0] START_RESET     = 16'd5000;
    localparam logic [CFG_W-1:0] GAP_RESET       = 16'd2250;
    localparam logic [CFG_W-1:0] ONE_EXTRA_RESET = 16'd3200;
    localparam logic [CFG_W-1:0] TERM_RESET      = 16'd2250;
    localparam logic [CFG_W-1:0] END_RESET       = 16'd2000;

    localparam int WORD_BITS_DEFAULT  = 16;
    localparam int TIMER_BITS_DEFAULT = 16;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SETUP = 3'd1,
        PH_START = 3'd2,
        PH_LOW   = 3'd3,
        PH_TERM  = 3'd4,
        PH_END   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_NONE     = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_BUSY     = 3'd2,
        ST_SENDING  = 3'd3,
        ST_FINISHED = 3'd4
    } status_t;

    // Timing registers, already masked to the timer width
    typedef struct packed {
        logic [CFG_W-1:0] setup_time;
        logic [CFG_W-1:0] start_time;
        logic [CFG_W-1:0] gap_time;
        logic [CFG_W-1:0] one_extra_time;
        logic [CFG_W-1:0] term_time;
        logic [CFG_W-1:0] end_time;
    } cfg_t;

    // One result item: pin controls after the step, plus status
    typedef struct packed {
        logic    data_enable;
        logic    data_level;
        logic    busy_enable;
        logic    busy_level;
        status_t status;
    } result_t;

endpackage

/* rtl/core/pulse_distance_word_transmitter.sv */
// pulse_distance_word_transmitter: top level of the pulse-distance word transmitter.
// Depends on pdwt_pkg, pdwt_regs and pdwt_seq.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one item per handshake: either a
//   command (func = 0) offering command_word, or a one-microsecond tick
//   (func = 1). busy_sense is the sampled shared busy line. A command is taken
//   only when no frame is running and busy_sense is low.
//   Output channel (out_valid/out_ready) returns exactly one item per input
//   item: the pin controls for data and busy as they stand after that item,
//   plus status (none, accepted, line busy, already sending, finished).
//   The frame is timed purely by tick items. The user must write the timing
//   registers over the APB port only while the block is idle; it is not enforced.
// Latency and throughput:
//   out_valid rises in the cycle after acceptance; one item per clock is sustained
//   while out_ready is high. The result register decouples the two sides, so a new
//   item is accepted in the same cycle an older result is taken. The per-item path
//   is one 17-bit add and compare on the tick counter.
// Reset: frame state idle, output empty, timing registers back to their reset
//   values; the pin and status fields of the result register are not reset.
// Stall: while out_ready is low and a result is held, in_ready drops; no
//   item is lost or dropped.

module pulse_distance_word_transmitter #(
    parameter int WORD_BITS  = pdwt_pkg::WORD_BITS_DEFAULT,
    parameter int TIMER_BITS = pdwt_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input items
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic [15:0]                  command_word,
    input  logic                         busy_sense,
    // result items
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         data_enable,
    output logic                         data_level,
    output logic                         busy_enable,
    output logic                         busy_level,
    output logic [2:0]                   status,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdwt_pkg::ADDR_W-1:0]  paddr,
    input  logic [pdwt_pkg::DATA_W-1:0]  pwdata,
    output logic [pdwt_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    pdwt_pkg::cfg_t     cfg;
    pdwt_pkg::result_t  step_result;
    pdwt_pkg::result_t  result_reg;
    logic               out_valid_reg;
    logic               step;

    // Output register is free when empty or being drained this cycle
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    pdwt_regs #(
        .TIMER_BITS (TIMER_BITS)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdwt_seq #(
        .WORD_BITS (WORD_BITS)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .func         (func),
        .command_word (command_word),
        .busy_sense   (busy_sense),
        .cfg          (cfg),
        .result       (step_result)
    );

    // Result register: control reset, payload loaded on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= step_result;
    end

    assign out_valid   = out_valid_reg;
    assign data_enable = result_reg.data_enable;
    assign data_level  = result_reg.data_level;
    assign busy_enable = result_reg.busy_enable;
    assign busy_level  = result_reg.busy_level;
    assign status      = result_reg.status;

endmodule

/* rtl/core/pdwt_regs.sv */
// pdwt_regs: APB timing registers of the transmitter.
// Depends on pdwt_pkg (cfg_t, register indexes, reset values).

module pdwt_regs #(
    parameter int TIMER_BITS = pdwt_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdwt_pkg::ADDR_W-1:0]  paddr,
    input  logic [pdwt_pkg::DATA_W-1:0]  pwdata,
    output logic [pdwt_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output pdwt_pkg::cfg_t               cfg
);

    // Stored width: bus field width, cut down to the timer width
    localparam int REG_W = (TIMER_BITS < pdwt_pkg::CFG_W) ? TIMER_BITS : pdwt_pkg::CFG_W;

    logic [REG_W-1:0] setup_reg;
    logic [REG_W-1:0] start_reg;
    logic [REG_W-1:0] gap_reg;
    logic [REG_W-1:0] one_extra_reg;
    logic [REG_W-1:0] term_reg;
    logic [REG_W-1:0] end_reg;

    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[pdwt_pkg::ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_reg     <= REG_W'(pdwt_pkg::SETUP_RESET);
            start_reg     <= REG_W'(pdwt_pkg::START_RESET);
            gap_reg       <= REG_W'(pdwt_pkg::GAP_RESET);
            one_extra_reg <= REG_W'(pdwt_pkg::ONE_EXTRA_RESET);
            term_reg      <= REG_W'(pdwt_pkg::TERM_RESET);
            end_reg       <= REG_W'(pdwt_pkg::END_RESET);
        end
        else if (wr_en)
        begin
            case (reg_idx)
                pdwt_pkg::REG_SETUP:     setup_reg     <= pwdata[REG_W-1:0];
                pdwt_pkg::REG_START:     start_reg     <= pwdata[REG_W-1:0];
                pdwt_pkg::REG_GAP:       gap_reg       <= pwdata[REG_W-1:0];
                pdwt_pkg::REG_ONE_EXTRA: one_extra_reg <= pwdata[REG_W-1:0];
                pdwt_pkg::REG_TERM:      term_reg      <= pwdata[REG_W-1:0];
                pdwt_pkg::REG_END:       end_reg       <= pwdata[REG_W-1:0];
                default: ;  // unmapped offset, write dropped
            endcase
        end
    end

    always_comb
    begin
        cfg.setup_time     = pdwt_pkg::CFG_W'(setup_reg);
        cfg.start_time     = pdwt_pkg::CFG_W'(start_reg);
        cfg.gap_time       = pdwt_pkg::CFG_W'(gap_reg);
        cfg.one_extra_time = pdwt_pkg::CFG_W'(one_extra_reg);
        cfg.term_time      = pdwt_pkg::CFG_W'(term_reg);
        cfg.end_time       = pdwt_pkg::CFG_W'(end_reg);
    end

    always_comb
    begin
        case (reg_idx)
            pdwt_pkg::REG_SETUP:     prdata = pdwt_pkg::DATA_W'(setup_reg);
            pdwt_pkg::REG_START:     prdata = pdwt_pkg::DATA_W'(start_reg);
            pdwt_pkg::REG_GAP:       prdata = pdwt_pkg::DATA_W'(gap_reg);
            pdwt_pkg::REG_ONE_EXTRA: prdata = pdwt_pkg::DATA_W'(one_extra_reg);
            pdwt_pkg::REG_TERM:      prdata = pdwt_pkg::DATA_W'(term_reg);
            pdwt_pkg::REG_END:       prdata = pdwt_pkg::DATA_W'(end_reg);
            default:                 prdata = '0;
        endcase
    end

endmodule

/* rtl/core/pdwt_seq.sv */
// pdwt_seq: frame sequencer (phase, tick counter, bit counter, shift word).
// Depends on pdwt_pkg (phase_t, status_t, cfg_t, result_t).

module pdwt_seq #(
    parameter int WORD_BITS = pdwt_pkg::WORD_BITS_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,         // item accepted this cycle
    input  logic               func,
    input  logic [15:0]        command_word,
    input  logic               busy_sense,
    input  pdwt_pkg::cfg_t     cfg,
    output pdwt_pkg::result_t  result
);

    localparam int BIT_W = $clog2(WORD_BITS + 1);
    localparam int TW    = pdwt_pkg::TICK_W;

    pdwt_pkg::phase_t       phase_reg, phase_next;
    logic [TW-1:0]          tick_reg, tick_next;
    logic [BIT_W-1:0]       bit_reg, bit_next;
    logic [WORD_BITS-1:0]   shift_reg, shift_next;

    logic [TW-1:0] tick_inc;
    logic [TW-1:0] len;
    logic          done;
    logic          last_bit;

    // Current phase length; a zero length behaves as one since tick_inc >= 1
    always_comb
    begin
        case (phase_reg)
            pdwt_pkg::PH_SETUP: len = TW'(cfg.setup_time);
            pdwt_pkg::PH_START: len = TW'(cfg.start_time);
            pdwt_pkg::PH_LOW:   len = TW'(cfg.gap_time)
                                    + (shift_reg[WORD_BITS-1] ? TW'(cfg.one_extra_time) : '0);
            pdwt_pkg::PH_TERM:  len = TW'(cfg.term_time);
            pdwt_pkg::PH_END:   len = TW'(cfg.end_time);
            default:            len = TW'(1);
        endcase
    end

    assign tick_inc = tick_reg + TW'(1);
    assign done     = (tick_inc >= len);
    assign last_bit = (bit_reg == BIT_W'(WORD_BITS - 1));

    // Next state
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        if (step)
        begin
            if (!func)
            begin
                if (phase_reg == pdwt_pkg::PH_IDLE && !busy_sense)
                begin
                    shift_next = WORD_BITS'(command_word);
                    bit_next   = '0;
                    tick_next  = '0;
                    phase_next = pdwt_pkg::PH_SETUP;
                end
            end
            else if (phase_reg != pdwt_pkg::PH_IDLE)
            begin
                if (done)
                begin
                    tick_next = '0;
                    case (phase_reg)
                        pdwt_pkg::PH_SETUP: phase_next = pdwt_pkg::PH_START;
                        pdwt_pkg::PH_START:
                        begin
                            phase_next = pdwt_pkg::PH_LOW;
                            bit_next   = '0;
                        end
                        pdwt_pkg::PH_LOW:   phase_next = pdwt_pkg::PH_TERM;
                        pdwt_pkg::PH_TERM:
                        begin
                            bit_next   = bit_reg + BIT_W'(1);
                            shift_next = shift_reg << 1;
                            phase_next = last_bit ? pdwt_pkg::PH_END : pdwt_pkg::PH_LOW;
                        end
                        pdwt_pkg::PH_END:
                        begin
                            phase_next = pdwt_pkg::PH_IDLE;
                            bit_next   = '0;
                        end
                        default:            phase_next = pdwt_pkg::PH_IDLE;
                    endcase
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
        end
    end

    // Outputs: status of this step, pins as they stand after it
    always_comb
    begin
        if (!func)
        begin
            if (phase_reg != pdwt_pkg::PH_IDLE)
                result.status = pdwt_pkg::ST_SENDING;
            else if (busy_sense)
                result.status = pdwt_pkg::ST_BUSY;
            else
                result.status = pdwt_pkg::ST_ACCEPTED;
        end
        else if (phase_reg == pdwt_pkg::PH_END && done)
        begin
            result.status = pdwt_pkg::ST_FINISHED;
        end
        else
        begin
            result.status = pdwt_pkg::ST_NONE;
        end

        result.data_enable = 1'b0;
        result.data_level  = 1'b0;
        result.busy_enable = 1'b0;
        result.busy_level  = 1'b0;
        case (phase_next)
            pdwt_pkg::PH_SETUP,
            pdwt_pkg::PH_LOW:
            begin
                result.busy_enable = 1'b1;
                result.busy_level  = 1'b1;
            end
            pdwt_pkg::PH_START,
            pdwt_pkg::PH_TERM:
            begin
                result.data_enable = 1'b1;
                result.data_level  = 1'b1;
                result.busy_enable = 1'b1;
                result.busy_level  = 1'b1;
            end
            pdwt_pkg::PH_END:
            begin
                result.data_enable = 1'b1;
                result.busy_enable = 1'b1;
                result.busy_level  = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pdwt_pkg::PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
        end
    end

    // Idle sequencer keeps its counters cleared
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pdwt_pkg::PH_IDLE) |-> (tick_reg == '0 && bit_reg == '0))
        else $error("counters not cleared while idle");

    // Bit counter sits at the word length exactly during the end phase
    a_end_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == pdwt_pkg::PH_END) |-> (bit_reg == BIT_W'(WORD_BITS)))
        else $error("end phase entered with bits left");

    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bit_reg <= BIT_W'(WORD_BITS)))
        else $error("bit counter out of range");

    // A command during a frame must not disturb it
    a_cmd_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !func && phase_reg != pdwt_pkg::PH_IDLE)
        |=> (phase_reg == $past(phase_reg) && tick_reg == $past(tick_reg)))
        else $error("command disturbed a running frame");

endmodule

/* tb/testbench.sv */
// testbench: self-checking bench for pulse_distance_word_transmitter.
// Depends on pdwt_pkg and the RTL top level; keeps its own model of the pin sequencer.
`timescale 1ns / 1ps

module testbench;

    // Register index with no register behind it; writes there must be ignored
    localparam logic [2:0] REG_UNUSED = 3'd6;
    localparam int         WORD_W     = 16;

    // One input item as queued for the driver
    typedef struct {
        logic        func;
        logic [15:0] word;
        logic        busy;
        bit          hold;   // wait for every result before presenting this item
    } bus_item_t;

    // ------------------------------------------------------------------
    // DUT signals; everything the bench drives starts at a known value
    // ------------------------------------------------------------------
    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          in_valid     = 1'b0;
    logic                          in_ready;
    logic                          func         = 1'b0;
    logic [15:0]                   command_word = '0;
    logic                          busy_sense   = 1'b0;
    logic                          out_valid;
    logic                          out_ready    = 1'b0;
    logic                          data_enable;
    logic                          data_level;
    logic                          busy_enable;
    logic                          busy_level;
    logic [2:0]                    status;
    logic                          psel         = 1'b0;
    logic                          penable      = 1'b0;
    logic                          pwrite       = 1'b0;
    logic [pdwt_pkg::ADDR_W-1:0]   paddr        = '0;
    logic [pdwt_pkg::DATA_W-1:0]   pwdata       = '0;
    logic [pdwt_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    pulse_distance_word_transmitter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .command_word (command_word),
        .busy_sense   (busy_sense),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_enable  (data_enable),
        .data_level   (data_level),
        .busy_enable  (busy_enable),
        .busy_level   (busy_level),
        .status       (status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    bus_item_t           item_queue[$];      // items waiting for the driver
    pdwt_pkg::result_t   expected_pins[$];   // predicted results, oldest first
    bus_item_t           cur_item;           // item currently offered on the input channel
    bit                  holding_item = 1'b0;
    bit                  no_idle      = 1'b0; // back-to-back phase, no idling
    int                  error_count  = 0;

    // stats for the summary line
    int          items_sent    = 0;
    int          results_seen  = 0;
    int          frames_done   = 0;
    int          words_taken   = 0;
    int          busy_rejects  = 0;
    int          sending_rejects = 0;

    // Shadow copy of the timing registers and the sequencer state
    logic [15:0]        timing_reg [0:5];
    pdwt_pkg::phase_t   cur_phase;
    logic [16:0]        tick_cnt;      // 17 bits: gap + one_extra can exceed 16
    int                 bit_pos;
    logic [15:0]        shift_reg;

    // Idle draws: a random wait per item, none during calm stretches or while no_idle is set
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        if (no_idle || calm)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    function automatic logic current_bit();
        if (bit_pos >= WORD_W)
            return 1'b0;
        return shift_reg[WORD_W - 1 - bit_pos];
    endfunction

    // Length of the running segment; zero durations act as one tick
    function automatic logic [16:0] segment_len();
        logic [16:0] d;
        case (cur_phase)
            pdwt_pkg::PH_SETUP: d = {1'b0, timing_reg[pdwt_pkg::REG_SETUP]};
            pdwt_pkg::PH_START: d = {1'b0, timing_reg[pdwt_pkg::REG_START]};
            pdwt_pkg::PH_LOW:
            begin
                d = {1'b0, timing_reg[pdwt_pkg::REG_GAP]};
                if (current_bit())
                    d = d + {1'b0, timing_reg[pdwt_pkg::REG_ONE_EXTRA]};
            end
            pdwt_pkg::PH_TERM:  d = {1'b0, timing_reg[pdwt_pkg::REG_TERM]};
            pdwt_pkg::PH_END:   d = {1'b0, timing_reg[pdwt_pkg::REG_END]};
            default:            d = 17'd1;
        endcase
        if (d == '0)
            d = 17'd1;
        return d;
    endfunction

    // Steps the shadow sequencer by one item and returns the pins after it
    task automatic pin_sequence_step(input bus_item_t it, output pdwt_pkg::result_t r);
        pdwt_pkg::status_t  st;
        logic [16:0]        len;
        st = pdwt_pkg::ST_NONE;
        if (!it.func)
        begin
            // a running frame wins over the busy line check
            if (cur_phase != pdwt_pkg::PH_IDLE)
                st = pdwt_pkg::ST_SENDING;
            else if (it.busy)
                st = pdwt_pkg::ST_BUSY;
            else
            begin
                shift_reg = it.word;
                bit_pos   = 0;
                tick_cnt  = '0;
                cur_phase = pdwt_pkg::PH_SETUP;
                st        = pdwt_pkg::ST_ACCEPTED;
            end
        end
        else if (cur_phase != pdwt_pkg::PH_IDLE)
        begin
            len      = segment_len();
            tick_cnt = tick_cnt + 17'd1;
            if (tick_cnt >= len)
            begin
                tick_cnt = '0;
                case (cur_phase)
                    pdwt_pkg::PH_SETUP: cur_phase = pdwt_pkg::PH_START;
                    pdwt_pkg::PH_START:
                    begin
                        cur_phase = pdwt_pkg::PH_LOW;
                        bit_pos   = 0;
                    end
                    pdwt_pkg::PH_LOW:   cur_phase = pdwt_pkg::PH_TERM;
                    pdwt_pkg::PH_TERM:
                    begin
                        bit_pos++;
                        cur_phase = (bit_pos >= WORD_W) ? pdwt_pkg::PH_END : pdwt_pkg::PH_LOW;
                    end
                    pdwt_pkg::PH_END:
                    begin
                        cur_phase = pdwt_pkg::PH_IDLE;
                        bit_pos   = 0;
                        st        = pdwt_pkg::ST_FINISHED;
                    end
                    default:            cur_phase = pdwt_pkg::PH_IDLE;
                endcase
            end
        end
        // tick while idle: nothing moves, status stays none

        // released pins read back as level 0
        r.data_enable = cur_phase inside {pdwt_pkg::PH_START, pdwt_pkg::PH_TERM,
                                          pdwt_pkg::PH_END};
        r.data_level  = cur_phase inside {pdwt_pkg::PH_START, pdwt_pkg::PH_TERM};
        r.busy_enable = (cur_phase != pdwt_pkg::PH_IDLE);
        r.busy_level  = (cur_phase != pdwt_pkg::PH_IDLE);
        r.status      = st;

        case (st)
            pdwt_pkg::ST_ACCEPTED: words_taken++;
            pdwt_pkg::ST_BUSY:     busy_rejects++;
            pdwt_pkg::ST_SENDING:  sending_rejects++;
            pdwt_pkg::ST_FINISHED: frames_done++;
            default:               ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Driver: presents queued items, predicts each one at acceptance
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : driver
        pdwt_pkg::result_t r;
        int      send_wait;
        bit      send_calm;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            holding_item = 1'b0;
            send_wait    = 0;
            send_calm    = 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pin_sequence_step(cur_item, r);
                expected_pins.push_back(r);
                holding_item = 1'b0;
                send_wait    = draw_wait(send_calm);
            end
            // only touch in_valid when nothing is on offer, so valid stays up
            // with a steady payload until the handshake
            if (!holding_item)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (item_queue.size() != 0 &&
                         !(item_queue[0].hold && expected_pins.size() != 0))
                begin
                    cur_item     = item_queue.pop_front();
                    func         <= cur_item.func;
                    command_word <= cur_item.word;
                    busy_sense   <= cur_item.busy;
                    in_valid     <= 1'b1;
                    holding_item = 1'b1;
                    items_sent++;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random backpressure, compares each result with the oldest
    // prediction
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        pdwt_pkg::result_t e;
        int      stall_left;
        bit      recv_calm;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left = 0;
            recv_calm  = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_pins.size() == 0)
                begin
                    $error("result with no item waiting for it");
                    error_count++;
                end
                else
                begin
                    e = expected_pins.pop_front();
                    check_field("data_enable", e.data_enable, data_enable);
                    check_field("data_level",  e.data_level,  data_level);
                    check_field("busy_enable", e.busy_enable, busy_enable);
                    check_field("busy_level",  e.busy_level,  busy_level);
                    check_field("status",      e.status,      status);
                end
                stall_left = draw_wait(recv_calm);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // APB access; transfers are separated by an idle state, which keeps psel to a
    // single assignment per edge
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // junk in the upper half; only the low 16 bits land in the register
        pwdata  <= {16'($urandom_range(0, 65535)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (idx <= pdwt_pkg::REG_END)
            timing_reg[idx] = value;
    endtask

    task automatic cfg_read(input logic [2:0] idx);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {16'h0000, timing_reg[idx]})
        begin
            $error("register %0d: expected %0h, got %0h", idx,
                   {16'h0000, timing_reg[idx]}, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic push_item(input logic f, input logic [15:0] w, input logic b,
                             input bit hold);
        bus_item_t it;
        it.func = f;
        it.word = w;
        it.busy = b;
        it.hold = hold;
        item_queue.push_back(it);
    endtask

    // Random tick; the unused word and busy bits still toggle
    task automatic push_tick();
        push_item(1'b1, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b0);
    endtask

    // Everything offered, accepted and answered
    task automatic wait_drained();
        while (item_queue.size() != 0 || holding_item || expected_pins.size() != 0)
            @(posedge clk);
    endtask

    // Registers may only change with the sequencer idle: tick the frame out
    task automatic finish_frame(input int batch);
        wait_drained();
        while (cur_phase != pdwt_pkg::PH_IDLE)
        begin
            for (int i = 0; i < batch; i++)
                push_tick();
            wait_drained();
        end
        // result path is one stage deep; let it settle before going on
        repeat (3) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_duration();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            7:       return 16'($urandom_range(4, 9));
            default: return 16'($urandom_range(1, 3));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Sequence of phases
    // ------------------------------------------------------------------
    initial
    begin : main
        logic [15:0] w;
        int          r;
        timing_reg[pdwt_pkg::REG_SETUP]     = pdwt_pkg::SETUP_RESET;
        timing_reg[pdwt_pkg::REG_START]     = pdwt_pkg::START_RESET;
        timing_reg[pdwt_pkg::REG_GAP]       = pdwt_pkg::GAP_RESET;
        timing_reg[pdwt_pkg::REG_ONE_EXTRA] = pdwt_pkg::ONE_EXTRA_RESET;
        timing_reg[pdwt_pkg::REG_TERM]      = pdwt_pkg::TERM_RESET;
        timing_reg[pdwt_pkg::REG_END]       = pdwt_pkg::END_RESET;
        cur_phase = pdwt_pkg::PH_IDLE;
        tick_cnt  = '0;
        bit_pos   = 0;
        shift_reg = '0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values of the registers
        for (int i = 0; i <= pdwt_pkg::REG_END; i++)
            cfg_read(3'(i));

        // Directed: idle tick does nothing, busy line rejects the word
        push_item(1'b1, 16'h0000, 1'b0, 1'b0);
        push_item(1'b0, 16'hFFFF, 1'b1, 1'b0);
        finish_frame(1);

        // all durations zero: every segment lasts a single tick
        for (int i = 0; i <= pdwt_pkg::REG_END; i++)
            cfg_write(3'(i), 16'd0);
        cfg_write(REG_UNUSED, 16'hFFFF);
        for (int i = 0; i <= pdwt_pkg::REG_END; i++)
            cfg_read(3'(i));

        // MSB and LSB set; commands during the frame bounce with status
        // "already sending", even with the busy line high
        push_item(1'b0, 16'h8001, 1'b0, 1'b0);
        push_item(1'b0, 16'h1234, 1'b1, 1'b0);
        push_item(1'b0, 16'h0000, 1'b0, 1'b1);  // sender waits for all results
        push_item(1'b1, 16'hFFFF, 1'b1, 1'b0);
        finish_frame(1);
        push_item(1'b0, 16'h0000, 1'b0, 1'b0);
        finish_frame(2);

        // start and term at their top value, checked by readback only
        cfg_write(pdwt_pkg::REG_START, 16'hFFFF);
        cfg_write(pdwt_pkg::REG_TERM,  16'hFFFF);
        cfg_read(pdwt_pkg::REG_START);
        cfg_read(pdwt_pkg::REG_TERM);

        // Random phases: short timings so frames complete, mostly ticks with
        // commands mixed in (accepted, busy-line and already-sending cases)
        for (int p = 0; p < 6; p++)
        begin
            for (int i = 0; i <= pdwt_pkg::REG_END; i++)
                cfg_write(3'(i), rand_duration());
            cfg_write(REG_UNUSED, 16'($urandom_range(0, 65535)));
            for (int i = 0; i <= pdwt_pkg::REG_END; i++)
                cfg_read(3'(i));
            for (int n = 0; n < 190; n++)
            begin
                r = $urandom_range(0, 99);
                w = 16'($urandom_range(0, 65535));
                if (r < 78)
                    push_tick();
                else
                    push_item(1'b0, w, 1'($urandom_range(0, 3) == 0),
                              $urandom_range(0, 49) == 0);
            end
            finish_frame(4);
        end

        // Back to back to the end: the first bit is a one whose low time
        // (gap + extra) no longer fits in 16 bits; the run stops while that
        // low time is still running, so the frame is left unfinished
        no_idle = 1'b1;
        cfg_write(pdwt_pkg::REG_SETUP,     16'd2);
        cfg_write(pdwt_pkg::REG_START,     16'd1);
        cfg_write(pdwt_pkg::REG_GAP,       16'd1);
        cfg_write(pdwt_pkg::REG_ONE_EXTRA, 16'hFFFF);
        cfg_write(pdwt_pkg::REG_TERM,      16'd0);
        cfg_write(pdwt_pkg::REG_END,       16'hFFFF);
        push_item(1'b0, 16'h8001, 1'b0, 1'b0);
        for (int i = 0; i < 80; i++)
        begin
            if (i % 20 == 10)
                push_item(1'b0, 16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b0);
            else
                push_tick();
        end
        wait_drained();
        no_idle = 1'b0;

        wait_drained();
        repeat (4) @(posedge clk);
        $display("Covered %0d items and %0d results: %0d words taken, %0d frames sent,",
                 items_sent, results_seen, words_taken, frames_done);
        $display("  %0d busy-line rejects, %0d rejects while sending",
                 busy_rejects, sending_rejects);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: the longest legal run is well under a tenth of this
    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
